@@ hw/rtl/gf256_pkg.sv @@
// Shared types, codes and helpers for the GF(2^8) arithmetic unit.
`default_nettype none

package gf256_pkg;

    // x^8 + x^4 + x^3 + x + 1
    localparam logic [8:0] GF_POLY = 9'h11B;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_MUL = 2'd1,
        CMD_INV = 2'd2,
        CMD_DIV = 2'd3
    } t_gf_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
    } t_gf_req;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       divide_error;
    } t_gf_rsp;

    // Degree of a polynomial of up to nine terms; zero and one both give 0.
    function automatic logic [3:0] f_degree(input logic [8:0] x);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 1; i < 9; i++) begin
            if (x[i]) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

    // Multiply by x modulo the field polynomial.
    function automatic logic [7:0] f_xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY[7:0] : 8'h00);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gf256_arithmetic_unit.sv @@
// Top level of the GF(2^8) arithmetic unit: add, multiply, inverse, quotient.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------
//  in      | to unit   | i_in_valid / o_in_stall      | i_in_req  (t_gf_req)
//  out     | from unit | o_out_valid / i_out_stall    | o_out_rsp (t_gf_rsp)
//
// One request is in work at a time; a request is taken in the idle cycle that
// follows the previous one, while the previous result may still wait in the
// output register. Add, divide by zero and inverse of zero need no work steps;
// multiply and quotient take one multiplier bit or one quotient bit per cycle;
// inverse takes one shift or add step of the binary Euclid loop per cycle.
// A stalled output only holds a finished request in the work registers until
// the output register frees. Reset is synchronous, active low, and clears the
// state machine and the output valid.
`default_nettype none

module gf256_arithmetic_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gf256_pkg::t_gf_req i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gf256_pkg::t_gf_rsp      o_out_rsp
);
    import gf256_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // control
    t_state      r_state,     n_state;
    t_gf_cmd     r_cmd,       n_cmd;
    logic        r_ready,     n_ready;      // work done, result in registers
    logic [2:0]  r_cnt,       n_cnt;        // bit step for multiply / quotient
    logic        r_out_valid, n_out_valid;

    // datapath
    logic [7:0]  r_a,   n_a;     // multiplicand, or running remainder
    logic [7:0]  r_b,   n_b;     // multiplier shift register (MSB first)
    logic [7:0]  r_acc, n_acc;   // product accumulator, or quotient shift reg
    logic [14:0] r_den, n_den;   // divisor, shifted right one place per step
    logic [3:0]  r_db,  n_db;    // divisor degree
    logic [8:0]  r_u,   n_u;     // Euclid: a*g1 = u, a*g2 = v (mod poly)
    logic [8:0]  r_v,   n_v;
    logic [7:0]  r_g1,  n_g1;
    logic [7:0]  r_g2,  n_g2;
    logic        r_err, n_err;
    t_gf_rsp     r_out, n_out;

    logic        w_take;
    logic        w_out_free;
    logic        w_load;
    logic [2:0]  w_s;
    logic [3:0]  w_pos;
    logic        w_hit;
    logic [7:0]  w_result;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    assign w_take     = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == ST_RUN) && r_ready && w_out_free;

    // quotient step: s counts 7 down to 0, tested bit is deg(b) + s
    assign w_s   = ~r_cnt;
    assign w_pos = r_db + {1'b0, w_s};
    assign w_hit = (w_pos <= 4'd7) && r_a[w_pos[2:0]];

    always_comb begin
        case (r_cmd)
            CMD_ADD: w_result = r_a ^ r_b;
            CMD_MUL: w_result = r_acc;
            CMD_INV: w_result = (r_u == 9'd1) ? r_g1 : r_g2;
            CMD_DIV: w_result = r_acc;
            default: w_result = 8'h00;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ready     = r_ready;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_den       = r_den;
        n_db        = r_db;
        n_u         = r_u;
        n_v         = r_v;
        n_g1        = r_g1;
        n_g2        = r_g2;
        n_err       = r_err;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_RUN;
                    n_cmd   = t_gf_cmd'(i_in_req.command);
                    n_a     = i_in_req.operand_a;
                    n_b     = i_in_req.operand_b;
                    n_acc   = 8'h00;
                    n_cnt   = 3'd0;
                    n_den   = {i_in_req.operand_b, 7'd0};
                    n_db    = f_degree({1'b0, i_in_req.operand_b});
                    n_u     = {1'b0, i_in_req.operand_a};
                    n_v     = GF_POLY;
                    n_g1    = 8'd1;
                    n_g2    = 8'd0;
                    n_err   = (n_cmd == CMD_DIV) && (i_in_req.operand_b == 8'h00);
                    // add, divide by zero and inverse of zero need no steps;
                    // inverse of zero falls out as g2 = 0 since u != 1
                    n_ready = (n_cmd == CMD_ADD) || n_err ||
                              ((n_cmd == CMD_INV) && (i_in_req.operand_a == 8'h00));
                end
            end
            ST_RUN: begin
                if (w_load) begin
                    n_state           = ST_IDLE;
                    n_out_valid       = 1'b1;
                    n_out.result_byte = w_result;
                    n_out.divide_error = r_err;
                end else if (!r_ready) begin
                    case (r_cmd)
                        CMD_MUL: begin
                            // Horner, multiplier MSB first
                            n_acc = f_xtime(r_acc) ^ (r_b[7] ? r_a : 8'h00);
                            n_b   = {r_b[6:0], 1'b0};
                            n_cnt = r_cnt + 3'd1;
                            if (r_cnt == 3'd7) begin
                                n_ready = 1'b1;
                            end
                        end
                        CMD_DIV: begin
                            if (w_hit) begin
                                n_a = r_a ^ r_den[7:0];
                            end
                            n_acc = {r_acc[6:0], w_hit};
                            n_den = {1'b0, r_den[14:1]};
                            n_cnt = r_cnt + 3'd1;
                            if (r_cnt == 3'd7) begin
                                n_ready = 1'b1;
                            end
                        end
                        CMD_INV: begin
                            if ((r_u == 9'd1) || (r_v == 9'd1)) begin
                                n_ready = 1'b1;
                            end else if (!r_u[0]) begin
                                n_u  = {1'b0, r_u[8:1]};
                                n_g1 = r_g1[0] ? 8'(({1'b0, r_g1} ^ GF_POLY) >> 1)
                                               : {1'b0, r_g1[7:1]};
                            end else if (!r_v[0]) begin
                                n_v  = {1'b0, r_v[8:1]};
                                n_g2 = r_g2[0] ? 8'(({1'b0, r_g2} ^ GF_POLY) >> 1)
                                               : {1'b0, r_g2[7:1]};
                            end else if (f_degree(r_u) > f_degree(r_v)) begin
                                n_u  = r_u ^ r_v;
                                n_g1 = r_g1 ^ r_g2;
                            end else begin
                                n_v  = r_v ^ r_u;
                                n_g2 = r_g2 ^ r_g1;
                            end
                        end
                        default: begin
                            n_ready = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmd       <= CMD_ADD;
            r_ready     <= 1'b0;
            r_cnt       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_ready     <= n_ready;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_den <= n_den;
        r_db  <= n_db;
        r_u   <= n_u;
        r_v   <= n_v;
        r_g1  <= n_g1;
        r_g2  <= n_g2;
        r_err <= n_err;
        r_out <= n_out;
    end

    // a taken request always blocks the input in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after taking a request");

    // a divide error always comes with a zero quotient
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.divide_error) |-> (o_out_rsp.result_byte == 8'h00))
        else $error("divide error with nonzero result");

    // Euclid operands stay nonzero while the inverse loop runs
    a_inv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && (r_cmd == CMD_INV) && !r_ready)
            |-> ((r_u != 9'd0) && (r_v != 9'd0)))
        else $error("inverse loop operand reached zero");

    // the output register is only loaded when its previous result is gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_rsp))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
